>>> rtl/esfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esfl_pkg
// Shared types and constants of the slot free list.
// ----------------------------------------------------------------------------
package esfl_pkg;

  localparam int unsigned SLOTS     = 1024;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned CAP_W     = IDX_W + 1;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned REG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_BUILD = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INITIAL_USED = 1'b0,
    REG_CAPACITY     = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_WALK,
    S_BUILD
  } state_e;

endpackage
`default_nettype wire

>>> rtl/element_slot_free_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// element_slot_free_list
// Linked free list of slot indices with a high-water mark.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// done_o for one cycle after the last working cycle, and the receiver cannot
// stall. Allocate reads the link RAM, then does the update. Free reads the
// valid RAM, then does the update; when the freed slot was the high-water
// mark and is above slot 1, a walk follows that reads each lower slot from
// the valid RAM, down to the first valid slot or to slot 1. Build is one
// sweep writing both RAMs, one entry a cycle. No-op, allocate on an empty
// list and free of slot 0 finish straight from the idle state.
// After reset a clearing pass over all SLOTS entries runs with busy high;
// configuration writes are taken at any time.
module element_slot_free_list
  import esfl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     cmd_i,
  input  wire logic [IDX_W-1:0]     slot_i,
  output logic                      done_o,
  output logic      [IDX_W-1:0]     granted_o,
  output logic      [STATUS_W-1:0]  status_o,
  output logic      [IDX_W-1:0]     high_mark_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CAP_W-1:0]     cfg_data_i
);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  top_q, top_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]  used_q, used_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic              done_q, done_d;
  logic [IDX_W-1:0]  granted_q, granted_d;
  status_e           status_q, status_d;
  logic [IDX_W-1:0]  init_used_q;
  logic [CAP_W-1:0]  capacity_q;

  logic              link_we;
  logic [IDX_W-1:0]  link_waddr, link_wdata, link_raddr, link_rdata;
  logic              vld_we;
  logic [IDX_W-1:0]  vld_waddr, vld_raddr;
  logic              vld_wdata, vld_rdata;

  logic [CAP_W-1:0]  cap_clamp;
  logic [IDX_W-1:0]  last_calc, used_calc;
  logic              accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign granted_o   = granted_q;
  assign status_o    = status_q;
  assign high_mark_o = top_q;

  always_comb begin
    cap_clamp = capacity_q;
    if (capacity_q > CAP_W'(SLOTS)) begin
      cap_clamp = CAP_W'(SLOTS);
    end else if (capacity_q == '0) begin
      cap_clamp = CAP_W'(1);
    end
    last_calc = IDX_W'(cap_clamp - CAP_W'(1));
    used_calc = (init_used_q > last_calc) ? last_calc : init_used_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_used_q <= '0;
      capacity_q  <= CAP_W'(SLOTS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_INITIAL_USED: init_used_q <= cfg_data_i[IDX_W-1:0];
        REG_CAPACITY:     capacity_q  <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      head_q    <= '0;
      top_q     <= '0;
      k_q       <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      top_q     <= top_d;
      k_q       <= k_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q    <= walk_d;
    slot_q    <= slot_d;
    used_q    <= used_d;
    last_q    <= last_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    top_d      = top_q;
    k_d        = k_q;
    walk_d     = walk_q;
    slot_d     = slot_q;
    used_d     = used_q;
    last_d     = last_q;
    done_d     = 1'b0;
    granted_d  = '0;
    status_d   = ST_OK;
    link_we    = 1'b0;
    link_waddr = k_q;
    link_wdata = '0;
    link_raddr = head_q;
    vld_we     = 1'b0;
    vld_waddr  = k_q;
    vld_wdata  = 1'b0;
    vld_raddr  = slot_i;

    unique case (state_q)
      S_CLEAR: begin
        link_we = 1'b1;
        vld_we  = 1'b1;
        k_d     = IDX_W'(k_q + 1'b1);
        if (k_q == IDX_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          slot_d = slot_i;
          unique case (cmd_e'(cmd_i))
            CMD_BUILD: begin
              used_d  = used_calc;
              last_d  = last_calc;
              k_d     = '0;
              state_d = S_BUILD;
            end
            CMD_ALLOC: begin
              if (head_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d = S_ALLOC;
              end
            end
            CMD_FREE: begin
              if (slot_i == '0) begin
                done_d   = 1'b1;
                status_d = ST_BAD_SLOT;
              end else begin
                state_d = S_FREE;
              end
            end
            CMD_NOP: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC: begin
        vld_we    = 1'b1;
        vld_waddr = head_q;
        vld_wdata = 1'b1;
        head_d    = link_rdata;
        if (head_q > top_q) begin
          top_d = head_q;
        end
        granted_d = head_q;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_FREE: begin
        if (!vld_rdata) begin
          done_d   = 1'b1;
          status_d = ST_BAD_SLOT;
          state_d  = S_IDLE;
        end else begin
          vld_we     = 1'b1;
          vld_waddr  = slot_q;
          link_we    = 1'b1;
          link_waddr = slot_q;
          link_wdata = head_q;
          head_d     = slot_q;
          vld_raddr  = IDX_W'(slot_q - 1'b1);
          walk_d     = IDX_W'(slot_q - 1'b1);
          if (slot_q != top_q) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else if (slot_q == IDX_W'(1)) begin
            top_d   = '0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        vld_raddr = IDX_W'(walk_q - 1'b1);
        walk_d    = IDX_W'(walk_q - 1'b1);
        if (vld_rdata) begin
          top_d   = walk_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (walk_q == IDX_W'(1)) begin
          top_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_BUILD: begin
        link_we   = 1'b1;
        vld_we    = 1'b1;
        vld_wdata = (k_q != '0) && (k_q <= used_q);
        if ((k_q > used_q) && (k_q < last_q)) begin
          link_wdata = IDX_W'(k_q + 1'b1);
        end
        k_d = IDX_W'(k_q + 1'b1);
        if (k_q == IDX_W'(SLOTS - 1)) begin
          head_d  = (used_q < last_q) ? IDX_W'(used_q + 1'b1) : '0;
          top_d   = used_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  esfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  esfl_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .raddr_i (vld_raddr),
    .rdata_o (vld_rdata)
  );

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted request neither in progress nor finished");

  a_done_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(accept)))
    else $error("result without a request");

  a_empty_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (granted_o == '0))
    else $error("slot granted on a failed request");

  a_grant_under_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (granted_o != '0)) |-> (high_mark_o >= granted_o))
    else $error("granted slot above high-water mark");

  a_alloc_head_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> (head_q != '0))
    else $error("allocate with an empty list");

endmodule
`default_nettype wire

>>> rtl/esfl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esfl_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module esfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
